// ===== rtl/stable_priority_queue_assert.svh =====
// assertion macros used by the priority queue sequencer
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// types and constants of the stable priority queue
package spq_pkg;

  localparam int unsigned PRI_W  = 4;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned STAT_W = 2;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REMOVED  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic             command;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } result_t;

endpackage

// ===== rtl/spq_if.sv =====
// command and response channel interfaces
interface spq_cmd_if
  import spq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             command;
  logic [PRI_W-1:0] priority_req;
  logic [ID_W-1:0]  entry_id;

  modport source (output valid, output command, output priority_req, output entry_id,
                  input ready);
  modport sink (input valid, input command, input priority_req, input entry_id,
                output ready);
endinterface

interface spq_rsp_if
  import spq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [PRI_W-1:0]  out_priority;

  modport source (output valid, output status, output out_id, output out_priority,
                  input ready);
  modport sink (input valid, input status, input out_id, input out_priority,
                output ready);
endinterface

// ===== rtl/stable_priority_queue.sv =====
// top level of the stable priority queue
// Sorted, stable priority queue of QUEUE_DEPTH entries held in a single-port-read,
// single-port-write memory; a sequencer moves one entry at a time (read, then
// write). An insert moves each held entry of higher priority value one slot toward
// the tail and writes the new entry into the freed slot; a remove takes the head
// and pulls every remaining entry one slot toward the head. A rejected insert or
// an empty remove moves no entry. Only one command is in work at a time; a new
// command is accepted while the previous response still waits in the output
// register. No clearing pass after reset.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_cmd_if.sink   cmd_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  cmd_t          cmd;
  result_t       res;
  logic          res_valid;
  logic          res_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          rsp_valid_q;
  result_t       rsp_q;

  assign cmd.command = cmd_i.command;
  assign cmd.pri     = cmd_i.priority_req;
  assign cmd.id      = cmd_i.entry_id;

  spq_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  spq_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_i       (cmd),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output register frees the sequencer once a response is parked
  assign res_ready = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_valid) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.out_id       = rsp_q.id;
  assign rsp_o.out_priority = rsp_q.pri;

endmodule

// ===== rtl/spq_mem.sv =====
// entry storage: one write port, one registered read port
module spq_mem
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spq_ctrl.sv =====
// sequencer that moves entries through the storage one step at a time
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cmd_t          cmd_i,
  input  logic          res_ready_i,
  output logic          res_valid_o,
  output result_t       res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

`include "stable_priority_queue_assert.svh"

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_REM_HEAD = 3'd3;
  localparam logic [2:0] S_REM_CAP  = 3'd4;
  localparam logic [2:0] S_REM_RD   = 3'd5;
  localparam logic [2:0] S_REM_WR   = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] fill_q, fill_d;
  entry_t        new_q, new_d;
  result_t       res_q, res_d;

  logic          accept;
  logic          step_down;
  logic [CW-1:0] pos_step;
  logic          held_greater;

  assign accept = cmd_valid_i && cmd_ready_o;

  // shared step unit: counts down in the insert states and in the remove write step, up in the other states
  assign step_down = (state_q == S_INS_RD) || (state_q == S_INS_CMP) ||
                     (state_q == S_REM_WR);
  assign pos_step  = step_down ? (pos_q - CW'(1)) : (pos_q + CW'(1));

  // compare: held entry must move behind the new one
  assign held_greater = mem_rdata_i.pri > new_q.pri;

  // sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    new_d       = new_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q[AW-1:0];
    mem_wdata_o = new_q;
    mem_raddr_o = pos_step[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          new_d.pri = cmd_i.pri;
          new_d.id  = cmd_i.id;
          res_d.id  = '0;
          res_d.pri = '0;
          pos_d     = fill_q;
          if (cmd_i.command == CMD_INSERT) begin
            if (fill_q == FULL_CNT) begin
              res_d.status = STAT_FULL;
              state_d      = S_FINISH;
            end else begin
              res_d.status = STAT_INSERTED;
              state_d      = S_INS_RD;
            end
          end else begin
            if (fill_q == '0) begin
              res_d.status = STAT_EMPTY;
              state_d      = S_FINISH;
            end else begin
              state_d = S_REM_HEAD;
            end
          end
        end
      end
      S_INS_RD: begin
        // at the head: the new entry lands in slot zero
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          fill_d   = fill_q + CW'(1);
          state_d  = S_FINISH;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we_o = 1'b1;
        if (held_greater) begin
          mem_wdata_o = mem_rdata_i;
          pos_d       = pos_step;
          state_d     = S_INS_RD;
        end else begin
          fill_d  = fill_q + CW'(1);
          state_d = S_FINISH;
        end
      end
      S_REM_HEAD: begin
        mem_raddr_o = '0;
        state_d     = S_REM_CAP;
      end
      S_REM_CAP: begin
        res_d.status = STAT_REMOVED;
        res_d.id     = mem_rdata_i.id;
        res_d.pri    = mem_rdata_i.pri;
        pos_d        = CW'(1);
        state_d      = S_REM_RD;
      end
      S_REM_RD: begin
        mem_raddr_o = pos_q[AW-1:0];
        if (pos_q == fill_q) begin
          fill_d  = fill_q - CW'(1);
          state_d = S_FINISH;
        end else begin
          state_d = S_REM_WR;
        end
      end
      S_REM_WR: begin
        // pull the entry one slot toward the head
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_step[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        pos_d       = pos_q + CW'(1);
        state_d     = S_REM_RD;
      end
      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    new_q <= new_d;
    res_q <= res_d;
  end

  assign cmd_ready_o = state_q == S_IDLE;
  assign res_valid_o = (state_q == S_FINISH) && res_ready_i;
  assign res_o       = res_q;

  `SPQ_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FULL_CNT, "fill count beyond depth")
  `SPQ_ASSERT_IMPL(a_write_state, clk_i, rst_ni, mem_we_o, (state_q == S_INS_RD) || (state_q == S_INS_CMP) || (state_q == S_REM_WR), "storage written outside a move step")
  `SPQ_ASSERT_IMPL(a_full_reject, clk_i, rst_ni, (state_q == S_FINISH) && (res_q.status == STAT_FULL), fill_q == FULL_CNT, "insert rejected while not full")
  `SPQ_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != S_IDLE, "transaction accepted without leaving idle")

endmodule

// ===== sim/stable_priority_queue_tb.sv =====
// testbench of the stable priority queue: directed and random commands checked against a shadow queue
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned PAUSE_AT     = 400;
  localparam int unsigned RSP_HOLD_AT  = 150;
  localparam int unsigned RSP_HOLD_LEN = 400;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // shadow of the sorted queue and the responses it predicts
  class queue_order_tracker #(int unsigned DEPTH = 16);
    entry_t      shadow_slots[DEPTH];
    int unsigned shadow_fill;
    result_t     expected_rsp_q[$];
    int unsigned mismatches;

    function new();
      shadow_fill = 0;
      mismatches  = 0;
    endfunction

    // predict the response of one accepted command
    function void note_command(cmd_t c);
      result_t     r;
      int unsigned pos;
      r.status = STAT_INSERTED;
      r.id     = '0;
      r.pri    = '0;
      if (c.command == CMD_INSERT) begin
        if (shadow_fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // new entry goes behind every entry of lower or equal priority
          pos = 0;
          while (pos < shadow_fill && shadow_slots[pos].pri <= c.pri) pos++;
          for (int unsigned k = shadow_fill; k > pos; k--) shadow_slots[k] = shadow_slots[k-1];
          shadow_slots[pos].pri = c.pri;
          shadow_slots[pos].id  = c.id;
          shadow_fill++;
        end
      end else begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // head leaves, the rest move up one slot
          r.status = STAT_REMOVED;
          r.id     = shadow_slots[0].id;
          r.pri    = shadow_slots[0].pri;
          for (int unsigned k = 1; k < shadow_fill; k++) shadow_slots[k-1] = shadow_slots[k];
          shadow_fill--;
        end
      end
      expected_rsp_q.push_back(r);
    endfunction

    function void flag_mismatch(string msg);
      if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    // compare one response transaction with the oldest prediction
    function void check_response(result_t act);
      result_t exp_r;
      if (expected_rsp_q.size() == 0) begin
        flag_mismatch($sformatf("response with nothing expected: status %0d id %h pri %h",
                                act.status, act.id, act.pri));
        return;
      end
      exp_r = expected_rsp_q.pop_front();
      if (act.status !== exp_r.status || act.id !== exp_r.id || act.pri !== exp_r.pri)
        flag_mismatch($sformatf("expected status %0d id %h pri %h, got status %0d id %h pri %h",
                                exp_r.status, exp_r.id, exp_r.pri,
                                act.status, act.id, act.pri));
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction
  endclass

  typedef queue_order_tracker #(QUEUE_DEPTH) tracker_t;

  logic clk_i;
  logic rst_ni;

  spq_cmd_if cmd_if ();
  spq_rsp_if rsp_if ();

  stable_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  tracker_t tracker = new();

  int unsigned rsp_seen;
  int unsigned cycle_count;
  bit          sender_burst;
  bit          rsp_hold_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one command and wait for its transaction
  task automatic send_cmd(logic cmd, logic [PRI_W-1:0] pri, logic [ID_W-1:0] id);
    cmd_t        c;
    int unsigned gap;
    c.command = cmd;
    c.pri     = pri;
    c.id      = id;
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= cmd;
    cmd_if.priority_req <= pri;
    cmd_if.entry_id     <= id;
    do @(posedge clk_i); while (!cmd_if.ready);
    tracker.note_command(c);
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // directed commands: empty remove, extremes, equal priorities, fill to full, full insert, removes
  task automatic run_directed();
    send_cmd(CMD_REMOVE, 4'hF, 16'hFFFF);
    send_cmd(CMD_INSERT, 4'hF, 16'hFFFF);
    send_cmd(CMD_INSERT, 4'h0, 16'h0000);
    send_cmd(CMD_INSERT, 4'h7, 16'h1111);
    send_cmd(CMD_INSERT, 4'h7, 16'h2222);
    send_cmd(CMD_INSERT, 4'h7, 16'h3333);
    send_cmd(CMD_INSERT, 4'h0, 16'h0001);
    send_cmd(CMD_INSERT, 4'hF, 16'h0002);
    for (int i = 0; i < 9; i++) send_cmd(CMD_INSERT, 4'(i * 5), 16'hA000 + 16'(i));
    send_cmd(CMD_INSERT, 4'h3, 16'hBEEF);
    repeat (4) send_cmd(CMD_REMOVE, 4'h0, 16'h0000);
  endtask

  // stimulus
  initial begin
    int unsigned     insert_pct;
    bit              narrow;
    logic [PRI_W-1:0] pri;
    rst_ni              <= 1'b0;
    cmd_if.valid        <= 1'b0;
    cmd_if.command      <= CMD_INSERT;
    cmd_if.priority_req <= '0;
    cmd_if.entry_id     <= '0;
    sender_burst = 1'b0;
    insert_pct   = 50;
    narrow       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // random phases that swing the queue between empty and full
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
        narrow = 1'($urandom_range(0, 1));
      end
      sender_burst = ((i / 50) % 4) == 1;
      // at PAUSE_AT the sender pauses until every response is back
      if (i == PAUSE_AT && tracker.pending() != 0) begin
        cmd_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk_i);
      end
      pri = narrow ? 4'($urandom_range(6, 8)) : 4'($urandom);
      send_cmd(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE, pri,
               16'($urandom));
    end
    sender_burst = 1'b0;
    cmd_if.valid <= 1'b0;

    // drain
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // response side ready, with one long hold-off
  initial begin
    int unsigned stall;
    int unsigned run;
    rsp_if.ready <= 1'b0;
    rsp_hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!rsp_hold_done && rsp_seen >= RSP_HOLD_AT) begin
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_LEN) @(posedge clk_i);
        rsp_hold_done = 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        rsp_if.ready <= 1'b1;
        run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 6);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    result_t act;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      act.status = status_e'(rsp_if.status);
      act.id     = rsp_if.out_id;
      act.pri    = rsp_if.out_priority;
      tracker.check_response(act);
      rsp_seen++;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
